@@ sv/v3n_pkg.sv @@
`default_nettype none
package v3n_pkg;

    // Control that travels down the row of cells with each request
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage
`default_nettype wire

@@ sv/v3n_square.sv @@
`default_nettype none
module v3n_square #(
    parameter int unsigned W  = 16,
    parameter int unsigned F  = 14,
    parameter int unsigned SW = 2 * W,
    parameter int unsigned BW = 2 * W + F + 2,
    parameter int unsigned RW = 2 * W + 2 * F + 5
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire [2:0][W-1:0]    i_comp,
    output v3n_pkg::t_ctl       o_ctl,
    output logic [SW-1:0]       o_s,
    output logic [2:0]          o_neg,
    output logic [2:0][F:0]     o_q,
    output logic [2:0][BW-1:0]  o_b,
    output logic [2:0][RW-1:0]  o_d
);

    logic [2:0][W-1:0]  mag;
    logic [2:0][SW-1:0] sq;
    logic [SW-1:0]      n_s;

    v3n_pkg::t_ctl      r_ctl;
    logic [SW-1:0]      r_s;
    logic [2:0]         r_neg;
    logic [2:0][RW-1:0] r_d;

    // Magnitudes and squares; the most negative code keeps its true size
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = i_comp[k][W-1] ? (~i_comp[k] + W'(1)) : i_comp[k];
            sq[k]  = SW'(mag[k]) * SW'(mag[k]);
        end
        n_s = sq[0] + sq[1] + sq[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.valid <= i_valid;
            r_ctl.zero  <= (n_s == '0);
        end
    end

    // Remainder starts at 4 * (|c| * 2^F)^2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= i_comp[k][W-1];
                r_d[k]   <= RW'(sq[k]) << (2 * F + 2);
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_neg = r_neg;
    assign o_q   = '0;
    assign o_b   = '0;
    assign o_d   = r_d;

endmodule
`default_nettype wire

@@ sv/v3n_cell.sv @@
`default_nettype none
module v3n_cell #(
    parameter int unsigned W   = 16,
    parameter int unsigned F   = 14,
    parameter int unsigned BIT = 0,
    parameter int unsigned SW  = 2 * W,
    parameter int unsigned BW  = 2 * W + F + 2,
    parameter int unsigned RW  = 2 * W + 2 * F + 5
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  v3n_pkg::t_ctl       i_ctl,
    input  wire [SW-1:0]        i_s,
    input  wire [2:0]           i_neg,
    input  wire [2:0][F:0]      i_q,
    input  wire [2:0][BW-1:0]   i_b,
    input  wire [2:0][RW-1:0]   i_d,
    output v3n_pkg::t_ctl       o_ctl,
    output logic [SW-1:0]       o_s,
    output logic [2:0]          o_neg,
    output logic [2:0][F:0]     o_q,
    output logic [2:0][BW-1:0]  o_b,
    output logic [2:0][RW-1:0]  o_d
);

    logic [RW-1:0]      ss;
    logic [2:0][RW-1:0] bb;
    logic [2:0][RW-1:0] t;
    logic [2:0]         take;
    logic [2:0][F:0]    n_q;
    logic [2:0][BW-1:0] n_b;
    logic [2:0][RW-1:0] n_d;

    v3n_pkg::t_ctl      r_ctl;
    logic [SW-1:0]      r_s;
    logic [2:0]         r_neg;
    logic [2:0][F:0]    r_q;
    logic [2:0][BW-1:0] r_b;
    logic [2:0][RW-1:0] r_d;

    // With u = 2q, B = u*S and D = R - u^2*S, the trial
    // (u + 2^(BIT+1) - 1)^2 * S <= R becomes T <= D with shifts and adds only
    always_comb begin
        ss = RW'(i_s);
        for (int k = 0; k < 3; k++) begin
            bb[k]   = RW'(i_b[k]);
            t[k]    = (bb[k] << (BIT + 2)) - (bb[k] << 1) + (ss << (2 * BIT + 2))
                      - (ss << (BIT + 2)) + ss;
            take[k] = !i_q[k][F] && ($signed(t[k]) <= $signed(i_d[k]));
            n_q[k]  = i_q[k];
            n_b[k]  = i_b[k];
            n_d[k]  = i_d[k];
            if (take[k]) begin
                n_q[k] = i_q[k] | ((F + 1)'(1) << BIT);
                n_b[k] = i_b[k] + (BW'(i_s) << (BIT + 1));
                n_d[k] = i_d[k] - (bb[k] << (BIT + 2)) - (ss << (2 * BIT + 2));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s   <= i_s;
            r_neg <= i_neg;
            r_q   <= n_q;
            r_b   <= n_b;
            r_d   <= n_d;
        end
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_neg = r_neg;
    assign o_q   = r_q;
    assign o_b   = r_b;
    assign o_d   = r_d;

endmodule
`default_nettype wire

@@ sv/vector3_normalize_top.sv @@
// Channel  | valid        | ready         | payload
// request  | i_in_valid   | o_in_ready    | i_x_in, i_y_in, i_z_in
// result   | o_out_valid  | i_out_ready   | o_x_unit, o_y_unit, o_z_unit, o_zero_length
//
// One request per cycle while the result is not stalled. The pipeline holds
// one squaring stage, then one cell per result bit, most significant first.
// Synchronous active-low reset clears the valid bits of all stages.
// A stalled result freezes the whole row; o_in_ready is low only then.
`default_nettype none
module vector3_normalize_top #(
    parameter int unsigned COMPONENT_WIDTH      = 16,
    parameter int unsigned OUTPUT_FRACTION_BITS = 14
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire [COMPONENT_WIDTH-1:0]        i_x_in,
    input  wire [COMPONENT_WIDTH-1:0]        i_y_in,
    input  wire [COMPONENT_WIDTH-1:0]        i_z_in,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [OUTPUT_FRACTION_BITS+1:0]  o_x_unit,
    output logic [OUTPUT_FRACTION_BITS+1:0]  o_y_unit,
    output logic [OUTPUT_FRACTION_BITS+1:0]  o_z_unit,
    output logic                             o_zero_length
);

    localparam int unsigned W  = COMPONENT_WIDTH;
    localparam int unsigned F  = OUTPUT_FRACTION_BITS;
    localparam int unsigned SW = 2 * W;
    localparam int unsigned BW = 2 * W + F + 2;
    localparam int unsigned RW = 2 * W + 2 * F + 5;
    localparam int unsigned NS = F + 2;

    v3n_pkg::t_ctl      st_ctl [NS];
    logic [SW-1:0]      st_s   [NS];
    logic [2:0]         st_neg [NS];
    logic [2:0][F:0]    st_q   [NS];
    logic [2:0][BW-1:0] st_b   [NS];
    logic [2:0][RW-1:0] st_d   [NS];

    logic               en;
    logic [2:0][F+1:0]  unit;

    assign en = !st_ctl[NS-1].valid || i_out_ready;

    v3n_square #(.W(W), .F(F), .SW(SW), .BW(BW), .RW(RW)) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_comp  ({i_z_in, i_y_in, i_x_in}),
        .o_ctl   (st_ctl[0]),
        .o_s     (st_s[0]),
        .o_neg   (st_neg[0]),
        .o_q     (st_q[0]),
        .o_b     (st_b[0]),
        .o_d     (st_d[0])
    );

    // Row of cells, one result bit each
    for (genvar i = 0; i < F + 1; i++) begin : g_cell
        v3n_cell #(.W(W), .F(F), .BIT(F - i), .SW(SW), .BW(BW), .RW(RW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (st_ctl[i]),
            .i_s     (st_s[i]),
            .i_neg   (st_neg[i]),
            .i_q     (st_q[i]),
            .i_b     (st_b[i]),
            .i_d     (st_d[i]),
            .o_ctl   (st_ctl[i+1]),
            .o_s     (st_s[i+1]),
            .o_neg   (st_neg[i+1]),
            .o_q     (st_q[i+1]),
            .o_b     (st_b[i+1]),
            .o_d     (st_d[i+1])
        );
    end

    // Apply sign; a zero vector gives zeros
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (st_ctl[NS-1].zero) begin
                unit[k] = '0;
            end else if (st_neg[NS-1][k]) begin
                unit[k] = '0 - (F + 2)'(st_q[NS-1][k]);
            end else begin
                unit[k] = (F + 2)'(st_q[NS-1][k]);
            end
        end
    end

    assign o_in_ready    = en;
    assign o_out_valid   = st_ctl[NS-1].valid;
    assign o_x_unit      = unit[0];
    assign o_y_unit      = unit[1];
    assign o_z_unit      = unit[2];
    assign o_zero_length = st_ctl[NS-1].zero;

`ifndef SYNTHESIS
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_length |-> o_x_unit == '0 && o_y_unit == '0 && o_z_unit == '0)
        else $error("zero vector gave nonzero result");
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $signed(o_x_unit) <= $signed((F + 2)'(1) << F)
                     && $signed(o_x_unit) >= -$signed((F + 2)'(1) << F))
        else $error("x result beyond unit range");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_y_unit))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
